[sv/isrt_pkg.sv]
// Shared types for the insertion sorter: input and result words, the
// per-cell control struct and the controller state encoding. No dependencies.
`default_nettype none

package isrt_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_word_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // insert the broadcast value this cycle
    logic pop;  // shift the whole row one place toward cell 0
  } cell_ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isrt_state_t;

endpackage

`default_nettype wire

[sv/insertion_sorter_top.sv]
// Top level of the stable insertion sorter: a row of isrt_cell instances and
// the fill/drain controller. Depends on isrt_pkg and isrt_cell.
//
// Usage: input words (value, last) arrive on the in_ channel with valid/ready.
// While the block fills, it accepts one word per cycle: every cell compares
// its element with the incoming value in the same cycle, the cells above the
// insertion point shift up one place, and the new value lands after all
// equal elements, so the order is stable. A word that arrives while all
// CAPACITY cells are full is dropped and the set is marked as overflowed.
// The word carrying last closes the set. Starting the next cycle the row
// drains through cell 0 on the out_ channel, one result word per cycle while
// out_ready is high, smallest first; the final word has final_res set and
// every word of the set carries the overflow flag. While draining, in_ready
// is low; a stall on out_ready simply holds the row. After the final word is
// taken the block returns to filling with an empty row and a cleared overflow
// flag. Reset empties the row (valid bits only) and puts the block in the
// filling state.
`default_nettype none

module insertion_sorter_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire isrt_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output isrt_pkg::out_word_t      out_data
);

  isrt_pkg::isrt_state_t state_r, state_nxt;
  logic                  dropped_r, dropped_nxt;
  isrt_pkg::cell_ctl_t   ctl;

  logic signed [isrt_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]                cell_valid;
  logic [CAPACITY-1:0]                cell_greater;

  logic in_accept;
  logic out_accept;
  logic row_full;

  assign row_full   = cell_valid[CAPACITY-1];
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // Output decode for the controller.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      isrt_pkg::ST_FILL: begin
        in_ready = 1'b1;
      end
      isrt_pkg::ST_DRAIN: begin
        out_valid = cell_valid[0];
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // A word that finds the row full is dropped but still counts for last.
  assign ctl.ins = in_accept && !row_full;
  assign ctl.pop = out_accept;

  // Next state: close the set on last, reopen after the final result.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isrt_pkg::ST_FILL: begin
        if (in_accept && in_data.last) begin
          state_nxt = isrt_pkg::ST_DRAIN;
        end
      end
      isrt_pkg::ST_DRAIN: begin
        if (out_accept && !cell_valid[1]) begin
          state_nxt = isrt_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = isrt_pkg::ST_FILL;
      end
    endcase
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (in_accept && row_full) begin
      dropped_nxt = 1'b1;
    end else if (out_accept && !cell_valid[1]) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= isrt_pkg::ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The row. Cell 0 sees a virtual left neighbor that is valid and never
  // greater; the top cell sees an empty right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [isrt_pkg::DATA_W-1:0] l_value;
    logic                               l_valid;
    logic                               l_greater;
    logic signed [isrt_pkg::DATA_W-1:0] r_value;
    logic                               r_valid;

    if (i == 0) begin : g_left_edge
      assign l_value   = '0;
      assign l_valid   = 1'b1;
      assign l_greater = 1'b0;
    end else begin : g_left
      assign l_value   = cell_value[i-1];
      assign l_valid   = cell_valid[i-1];
      assign l_greater = cell_greater[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_right
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    isrt_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .bcast_value  (in_data.value),
      .left_value   (l_value),
      .left_valid   (l_valid),
      .left_greater (l_greater),
      .right_value  (r_value),
      .right_valid  (r_valid),
      .value        (cell_value[i]),
      .valid        (cell_valid[i]),
      .greater      (cell_greater[i])
    );
  end

  // The head cell is the output register; the word is final when the cell
  // behind it is empty.
  assign out_data.sorted_value = cell_value[0];
  assign out_data.final_res    = !cell_valid[1];
  assign out_data.overflow     = dropped_r;

endmodule

`default_nettype wire

[sv/isrt_cell.sv]
// One cell of the insertion row: holds one element and its valid bit.
// Depends on isrt_pkg for the data width and the control struct.
`default_nettype none

module isrt_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire isrt_pkg::cell_ctl_t               ctl,
  input  wire logic signed [isrt_pkg::DATA_W-1:0] bcast_value,
  input  wire logic signed [isrt_pkg::DATA_W-1:0] left_value,
  input  wire logic                              left_valid,
  input  wire logic                              left_greater,
  input  wire logic signed [isrt_pkg::DATA_W-1:0] right_value,
  input  wire logic                              right_valid,
  output logic signed [isrt_pkg::DATA_W-1:0]     value,
  output logic                                   valid,
  output logic                                   greater
);

  logic signed [isrt_pkg::DATA_W-1:0] value_r, value_nxt;
  logic                               valid_r, valid_nxt;

  // An empty cell counts as holding a value above everything.
  assign greater = !valid_r || (value_r > bcast_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.pop) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctl.ins) begin
      valid_nxt = valid_r | left_valid;
      if (greater) begin
        value_nxt = left_greater ? left_value : bcast_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

[test/tb_insertion_sorter_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter_top: a scoreboard class that predicts
// the sorted output of every set, plus tasks and processes that drive and stall both channels.
// Depends on isrt_pkg and the insertion sorter RTL.

// Predicts the sorted sets and compares every result word with the oldest prediction.
class sort_scoreboard #(parameter int unsigned SLOTS = 64);
  logic signed [isrt_pkg::DATA_W-1:0] held [SLOTS];
  int unsigned                         held_count;
  bit                                  dropped;
  isrt_pkg::out_word_t                 sorted_queue [$];
  int unsigned                         error_count;

  function new();
    held_count  = 0;
    dropped     = 1'b0;
    error_count = 0;
  endfunction

  // Inserts one accepted value after all equal ones; a closing word releases the set.
  function void note_input(isrt_pkg::in_word_t w);
    int unsigned         pos;
    int unsigned         k;
    isrt_pkg::out_word_t r;
    if (held_count >= SLOTS) begin
      dropped = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && $signed(held[pos-1]) > $signed(w.value)) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = w.value;
      held_count++;
    end
    if (w.last) begin
      for (k = 0; k < held_count; k++) begin
        r.sorted_value = held[k];
        r.final_res    = (k + 1 == held_count);
        r.overflow     = dropped;
        sorted_queue.push_back(r);
      end
      held_count = 0;
      dropped    = 1'b0;
    end
  endfunction

  function void check_result(isrt_pkg::out_word_t got);
    isrt_pkg::out_word_t want;
    if (sorted_queue.size() == 0) begin
      $error("unexpected result word: sorted_value=%0d final_res=%0b overflow=%0b",
             got.sorted_value, got.final_res, got.overflow);
      error_count++;
      return;
    end
    want = sorted_queue.pop_front();
    if (got.sorted_value !== want.sorted_value) begin
      $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
      error_count++;
    end
    if (got.final_res !== want.final_res) begin
      $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
      error_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      error_count++;
    end
  endfunction

  function int unsigned pending();
    return sorted_queue.size();
  endfunction
endclass

module tb_insertion_sorter_top;

  localparam int unsigned CAPACITY     = 64;
  // Margin after the last predicted result, so that nothing stray is still on its way out.
  localparam int unsigned SETTLE       = 8;
  // Length of the one long receiver hold-off, in cycles.
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_ITEMS = 160;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  isrt_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  isrt_pkg::out_word_t out_data;

  sort_scoreboard #(CAPACITY) sb;

  // Words waiting to be offered on the input channel, in order.
  isrt_pkg::in_word_t word_q [$];

  // Raised by the stimulus to ask the receiver for its long hold-off.
  bit hold_req;

  // Burst bookkeeping of the sender; it survives from one set to the next so that
  // gaps fall at random places within the sets.
  int unsigned burst_left;

  insertion_sorter_top #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling on the run.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // Both handshakes are observed at the clock edge. Inputs are noted before results
  // are checked, although a set's results can never share an edge with its own words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  // Receiver: stretches of random length, each with its own stall pattern, from
  // always ready to mostly stalled. On request it holds off for one long hold-off so
  // that the row cannot drain and the input channel backs up behind it.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned n;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 24);
        for (n = 0; n < len && !hold_req; n++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Queues one set; the final value carries the last flag.
  function automatic void add_set(input logic signed [31:0] vals [$]);
    isrt_pkg::in_word_t w;
    int                 i;
    for (i = 0; i < vals.size(); i++) begin
      w.value = vals[i];
      w.last  = (i == vals.size() - 1);
      word_q.push_back(w);
    end
  endfunction

  // Offers every queued word, holding valid and payload until the word is taken.
  // With gaps enabled the sender works in bursts separated by idle cycles. Valid is
  // left high after the final word unless a gap follows it; the caller either offers
  // more words at once or lowers it through wait_drained.
  task automatic play_words(input bit with_gaps);
    isrt_pkg::in_word_t w;
    int unsigned        gap;
    while (word_q.size() != 0) begin
      w = word_q.pop_front();
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk); while (!in_ready);
      if (with_gaps) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap        = $urandom_range(1, 8);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // Stops offering and waits until every predicted result word has come out. The
  // first edge lets the monitor note a word taken at the edge just passed.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Picks a value: full-range, near zero for ties, 0 to 1000, negative, or an extreme.
  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      return $urandom;
    end else if (sel <= 6) begin
      return $urandom_range(0, 8) - 4;
    end else if (sel == 7) begin
      return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
    end else if (sel == 8) begin
      return $urandom_range(0, 1000);
    end
    return -$signed($urandom_range(1, 32'h7fff_ffff));
  endfunction

  initial begin
    logic signed [31:0] vals [$];
    int unsigned        set_idx;
    int unsigned        sent;
    int unsigned        n;
    int unsigned        k;

    sb         = new();
    hold_req   = 1'b0;
    burst_left = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets, offered back to back: single-element sets at both extremes,
    // a mixed set with ties and extremes, descending and ascending runs, a set of
    // equal values, and alternating bit patterns.
    add_set('{INT_MIN});
    add_set('{INT_MAX});
    add_set('{32'sd5, 32'sd3, 32'sd5, -32'sd1, INT_MAX, INT_MIN, 32'sd0, -32'sd1});
    add_set('{32'sd4, 32'sd3, 32'sd2, 32'sd1});
    add_set('{-32'sd2, -32'sd1, 32'sd0, 32'sd1});
    add_set('{32'sd7, 32'sd7, 32'sd7});
    add_set('{32'sh5555_5555, 32'shAAAA_AAAA});
    play_words(1'b0);
    wait_drained();

    // Random sets. Most are small; one fills the row exactly, and one runs past the
    // capacity so that ordinary words and the closing word are both dropped.
    set_idx = 0;
    sent    = 0;
    while (sent < RANDOM_ITEMS) begin
      case (set_idx)
        2:       n = CAPACITY;
        6:       n = CAPACITY + 2 + $urandom_range(0, 3);
        default: n = $urandom_range(1, 8);
      endcase
      vals.delete();
      for (k = 0; k < n; k++) begin
        vals.push_back(pick_value());
      end
      add_set(vals);
      sent += n;
      // One set drains into a receiver that holds off for a long time, while the
      // next sets keep being offered against a low in_ready.
      if (set_idx == 4) begin
        hold_req = 1'b1;
      end
      // Once the sender waits until the block has nothing left to deliver.
      if (set_idx == 9) begin
        wait_drained();
      end
      play_words(1'b1);
      set_idx++;
    end

    wait_drained();
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
